/* hw/rtl/touch_point_calibrate_macros.svh */
// ----------------------------------------------------------------------------
// touch_point_calibrate assertion macros
// Shared concurrent assertion forms for the calibration pipeline.
// ----------------------------------------------------------------------------
`ifndef TOUCH_POINT_CALIBRATE_MACROS_SVH
`define TOUCH_POINT_CALIBRATE_MACROS_SVH

// holds at every edge out of reset
`define TPC_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("touch_point_calibrate: invariant violated");

// antecedent implies consequent in the same cycle
`define TPC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch_point_calibrate: implication violated");

`endif

/* hw/rtl/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg
// Types and constants shared by the touch point calibration pipeline.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COORD_W     = 12;
  localparam int SIZE_W      = 13;
  localparam int MODE_W      = 3;
  localparam int PROD_W      = SAMPLE_BITS + COORD_W;
  localparam int DIV_STEP    = 2;
  localparam int DIV_STAGES  = COORD_W / DIV_STEP;
  localparam int PIPE_DEPTH  = DIV_STAGES + 3;
  localparam int FLIGHT_W    = $clog2(PIPE_DEPTH + 1);
  localparam int REG_COUNT   = 8;
  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int PADDR_W     = REG_IDX_W + 2;
  localparam int PDATA_W     = 32;

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  localparam int MODE_SWAP  = 0;
  localparam int MODE_INV_X = 1;
  localparam int MODE_INV_Y = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_X_MIN     = 3'd1,
    REG_X_MAX     = 3'd2,
    REG_Y_MIN     = 3'd3,
    REG_Y_MAX     = 3'd4,
    REG_WIDTH     = 3'd5,
    REG_HEIGHT    = 3'd6,
    REG_MODE      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pressure;
    logic [SAMPLE_BITS-1:0] raw_x;
    logic [SAMPLE_BITS-1:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic [COORD_W-1:0]     point_x;
    logic [COORD_W-1:0]     point_y;
    logic [SAMPLE_BITS-1:0] strength;
    logic                   touches;
    logic                   pressed;
  } point_t;

  // live calibration, raw registers plus per-axis derived terms
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] thr;
    logic [SAMPLE_BITS-1:0] x_lo;
    logic [SAMPLE_BITS-1:0] x_hi;
    logic [SAMPLE_BITS-1:0] y_lo;
    logic [SAMPLE_BITS-1:0] y_hi;
    logic [SAMPLE_BITS-1:0] dx;
    logic [SAMPLE_BITS-1:0] dy;
    logic [COORD_W-1:0]     span_x;
    logic [COORD_W-1:0]     span_y;
    logic                   x_flat;
    logic                   y_flat;
    logic                   x_rev;
    logic                   y_rev;
    logic                   swap;
    logic                   inv_x;
    logic                   inv_y;
  } calib_t;

  // restoring divider state: partial remainder, dividend low bits / quotient
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] rem;
    logic [COORD_W-1:0]     lq;
  } axis_div_t;

  typedef struct packed {
    logic                   pressed;
    logic [SAMPLE_BITS-1:0] strength;
    axis_div_t              ax;
    axis_div_t              ay;
  } div_t;

endpackage

/* hw/rtl/tpc_regs.sv */
// ----------------------------------------------------------------------------
// tpc_regs
// APB register file and derived per-axis calibration terms.
// ----------------------------------------------------------------------------
module tpc_regs
  import tpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output calib_t             calib
);

  logic [SAMPLE_BITS-1:0] thr;
  logic [SAMPLE_BITS-1:0] x_lo;
  logic [SAMPLE_BITS-1:0] x_hi;
  logic [SAMPLE_BITS-1:0] y_lo;
  logic [SAMPLE_BITS-1:0] y_hi;
  logic [SIZE_W-1:0]      width;
  logic [SIZE_W-1:0]      height;
  logic [MODE_W-1:0]      mode;
  logic                   wr;
  reg_idx_t               idx;

  function automatic logic [COORD_W-1:0] span_of(logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] s;
    s = size - SIZE_W'(1);
    if (size == '0) begin
      return '0;
    end else if (s > SIZE_W'(COORD_MAX)) begin
      return COORD_MAX;
    end else begin
      return s[COORD_W-1:0];
    end
  endfunction

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= '0;
      x_lo   <= '0;
      x_hi   <= SAMPLE_BITS'(4095);
      y_lo   <= '0;
      y_hi   <= SAMPLE_BITS'(4095);
      width  <= SIZE_W'(320);
      height <= SIZE_W'(240);
      mode   <= '0;
    end else if (wr) begin
      case (idx)
        REG_THRESHOLD: thr    <= pwdata[SAMPLE_BITS-1:0];
        REG_X_MIN:     x_lo   <= pwdata[SAMPLE_BITS-1:0];
        REG_X_MAX:     x_hi   <= pwdata[SAMPLE_BITS-1:0];
        REG_Y_MIN:     y_lo   <= pwdata[SAMPLE_BITS-1:0];
        REG_Y_MAX:     y_hi   <= pwdata[SAMPLE_BITS-1:0];
        REG_WIDTH:     width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:    height <= pwdata[SIZE_W-1:0];
        REG_MODE:      mode   <= pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = PDATA_W'(thr);
      REG_X_MIN:     prdata = PDATA_W'(x_lo);
      REG_X_MAX:     prdata = PDATA_W'(x_hi);
      REG_Y_MIN:     prdata = PDATA_W'(y_lo);
      REG_Y_MAX:     prdata = PDATA_W'(y_hi);
      REG_WIDTH:     prdata = PDATA_W'(width);
      REG_HEIGHT:    prdata = PDATA_W'(height);
      REG_MODE:      prdata = PDATA_W'(mode);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    calib.thr    = thr;
    calib.x_lo   = x_lo;
    calib.x_hi   = x_hi;
    calib.y_lo   = y_lo;
    calib.y_hi   = y_hi;
    calib.dx     = x_hi - x_lo;
    calib.dy     = y_hi - y_lo;
    calib.span_x = span_of(width);
    calib.span_y = span_of(height);
    calib.x_flat = (x_lo == x_hi);
    calib.y_flat = (y_lo == y_hi);
    calib.x_rev  = (x_lo > x_hi);
    calib.y_rev  = (y_lo > y_hi);
    calib.swap   = mode[MODE_SWAP];
    calib.inv_x  = mode[MODE_INV_X];
    calib.inv_y  = mode[MODE_INV_Y];
  end

endmodule

/* hw/rtl/tpc_front.sv */
// ----------------------------------------------------------------------------
// tpc_front
// Threshold, swap and window clamp, then offset times span, two stages.
// ----------------------------------------------------------------------------
module tpc_front
  import tpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  calib_t  calib,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output div_t    out_data
);

  typedef struct packed {
    logic                   pressed;
    logic [SAMPLE_BITS-1:0] strength;
    logic [SAMPLE_BITS-1:0] nx;
    logic [SAMPLE_BITS-1:0] ny;
  } prep_t;

  function automatic logic [SAMPLE_BITS-1:0] clamp_off(
    logic [SAMPLE_BITS-1:0] raw, logic [SAMPLE_BITS-1:0] lo, logic [SAMPLE_BITS-1:0] hi);
    logic [SAMPLE_BITS-1:0] c;
    if (raw < lo) begin
      c = lo;
    end else if (raw > hi) begin
      c = hi;
    end else begin
      c = raw;
    end
    return c - lo;
  endfunction

  logic                   v1;
  prep_t                  d1;
  prep_t                  d1_next;
  logic                   rdy1;
  logic                   rdy2;
  logic [SAMPLE_BITS-1:0] rx;
  logic [SAMPLE_BITS-1:0] ry;
  logic [PROD_W-1:0]      px;
  logic [PROD_W-1:0]      py;

  assign rdy2     = !out_valid || !out_stall;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_comb begin
    rx = calib.swap ? in_data.raw_y : in_data.raw_x;
    ry = calib.swap ? in_data.raw_x : in_data.raw_y;
    d1_next.pressed  = (in_data.pressure >= calib.thr);
    d1_next.strength = in_data.pressure;
    d1_next.nx       = clamp_off(rx, calib.x_lo, calib.x_hi);
    d1_next.ny       = clamp_off(ry, calib.y_lo, calib.y_hi);
  end

  assign px = PROD_W'(d1.nx) * PROD_W'(calib.span_x);
  assign py = PROD_W'(d1.ny) * PROD_W'(calib.span_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      d1 <= d1_next;
    end
    if (rdy2 && v1) begin
      out_data.pressed  <= d1.pressed;
      out_data.strength <= d1.strength;
      out_data.ax.rem   <= px[PROD_W-1:COORD_W];
      out_data.ax.lq    <= px[COORD_W-1:0];
      out_data.ay.rem   <= py[PROD_W-1:COORD_W];
      out_data.ay.lq    <= py[COORD_W-1:0];
    end
  end

endmodule

/* hw/rtl/tpc_div_stage.sv */
// ----------------------------------------------------------------------------
// tpc_div_stage
// One restoring-division stage, DIV_STEP quotient bits per axis.
// ----------------------------------------------------------------------------
module tpc_div_stage
  import tpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  calib_t calib,
  input  logic   in_valid,
  output logic   in_stall,
  input  div_t   in_data,
  output logic   out_valid,
  input  logic   out_stall,
  output div_t   out_data
);

  function automatic axis_div_t div_step(axis_div_t a, logic [SAMPLE_BITS-1:0] d);
    logic [SAMPLE_BITS:0] t;
    logic                 qb;
    axis_div_t            r;
    t  = {a.rem, a.lq[COORD_W-1]};
    qb = (t >= {1'b0, d});
    if (qb) begin
      t = t - {1'b0, d};
    end
    r.rem = t[SAMPLE_BITS-1:0];
    r.lq  = {a.lq[COORD_W-2:0], qb};
    return r;
  endfunction

  logic rdy;
  div_t nxt;

  assign rdy      = !out_valid || !out_stall;
  assign in_stall = !rdy;

  always_comb begin
    nxt = in_data;
    for (int k = 0; k < DIV_STEP; k++) begin
      nxt.ax = div_step(nxt.ax, calib.dx);
      nxt.ay = div_step(nxt.ay, calib.dy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

/* hw/rtl/tpc_back.sv */
// ----------------------------------------------------------------------------
// tpc_back
// Window special cases, inversion, no-touch masking and output register.
// ----------------------------------------------------------------------------
module tpc_back
  import tpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  calib_t calib,
  input  logic   in_valid,
  output logic   in_stall,
  input  div_t   in_data,
  output logic   out_valid,
  input  logic   out_stall,
  output point_t out_data
);

  function automatic logic [COORD_W-1:0] finish(
    logic [COORD_W-1:0] q, logic [COORD_W-1:0] span, logic flat, logic rev, logic inv);
    logic [COORD_W-1:0] v;
    v = rev ? span : q;
    if (v > span) begin
      v = span;
    end
    if (inv) begin
      v = span - v;
    end
    return flat ? '0 : v;
  endfunction

  logic   rdy;
  point_t nxt;

  assign rdy      = !out_valid || !out_stall;
  assign in_stall = !rdy;

  always_comb begin
    nxt = '0;
    if (in_data.pressed) begin
      nxt.point_x  = finish(in_data.ax.lq, calib.span_x, calib.x_flat, calib.x_rev,
                            calib.inv_x);
      nxt.point_y  = finish(in_data.ay.lq, calib.span_y, calib.y_flat, calib.y_rev,
                            calib.inv_y);
      nxt.strength = in_data.strength;
      nxt.touches  = 1'b1;
      nxt.pressed  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

/* hw/rtl/touch_point_calibrate.sv */
// ----------------------------------------------------------------------------
// touch_point_calibrate
// Linear calibration of resistive touch samples to pixel coordinates.
// ----------------------------------------------------------------------------
// Input beats (sample) carry pressure, raw_x, raw_y; output beats (point)
// carry point_x, point_y, strength, touches, pressed. One output beat per
// input beat, in order. Both channels: a beat moves when valid is high and
// stall is low.
// Pipeline: prep, multiply, six division stages (two quotient bits each),
// finish. One beat per cycle is sustained while point_stall stays low.
// Every stage holds its own valid bit and only stalls when its successor
// is full and stalled, so bubbles are squeezed out and up to nine beats
// can sit in flight before sample_stall rises.
// Configuration: APB writes at byte address 4*index, read back on prdata,
// pready tied high. Write only while no beat is in flight.
// Reset (rst, synchronous) empties the pipeline and loads register defaults:
// threshold 0, windows 0..4095, 320 x 240, no swap or inversion.
// ----------------------------------------------------------------------------
`include "touch_point_calibrate_macros.svh"

module touch_point_calibrate
  import tpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  sample_t            sample,
  output logic               point_valid,
  input  logic               point_stall,
  output point_t             point
);

  calib_t                calib;
  logic [DIV_STAGES:0]   dv;
  logic [DIV_STAGES:0]   ds;
  div_t                  dd [DIV_STAGES+1];
  logic [FLIGHT_W-1:0]   flight;
  logic [FLIGHT_W-1:0]   flight_next;

  tpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .calib   (calib)
  );

  tpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .calib     (calib),
    .in_valid  (sample_valid),
    .in_stall  (sample_stall),
    .in_data   (sample),
    .out_valid (dv[0]),
    .out_stall (ds[0]),
    .out_data  (dd[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    tpc_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .calib     (calib),
      .in_valid  (dv[i]),
      .in_stall  (ds[i]),
      .in_data   (dd[i]),
      .out_valid (dv[i+1]),
      .out_stall (ds[i+1]),
      .out_data  (dd[i+1])
    );
  end

  tpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .calib     (calib),
    .in_valid  (dv[DIV_STAGES]),
    .in_stall  (ds[DIV_STAGES]),
    .in_data   (dd[DIV_STAGES]),
    .out_valid (point_valid),
    .out_stall (point_stall),
    .out_data  (point)
  );

  // beats accepted but not yet delivered
  always_comb begin
    flight_next = flight;
    if (sample_valid && !sample_stall) begin
      flight_next = flight_next + FLIGHT_W'(1);
    end
    if (point_valid && !point_stall) begin
      flight_next = flight_next - FLIGHT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flight <= '0;
    end else begin
      flight <= flight_next;
    end
  end

  `TPC_ASSERT_IMP(a_stall_only_when_full, clk, rst, sample_stall, point_valid && point_stall)
  `TPC_ASSERT_ALWAYS(a_flight_bound, clk, rst, flight <= FLIGHT_W'(PIPE_DEPTH))
  `TPC_ASSERT_IMP(a_no_invented_beat, clk, rst, flight == '0, !point_valid)
  `TPC_ASSERT_IMP(a_no_touch_zero, clk, rst, point_valid && !point.pressed, point == '0)

endmodule

/* sim/tb_touch_point_calibrate.sv */
// ----------------------------------------------------------------------------
// tb_touch_point_calibrate
// Self-checking bench for the touch point calibration pipeline. A short
// directed table covers thresholds, swap and inversion, empty and reversed
// windows, zero and oversized screens; randomized phases follow, each with a
// new calibration loaded over APB and read back. Every output beat is
// compared in order against its table entry or a local calibration
// predictor, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_touch_point_calibrate;
  timeunit 1ns;
  timeprecision 1ps;
  import tpc_pkg::*;

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    reg_idx_t           idx;
    logic [PDATA_W-1:0] value;
    sample_t            smp;
    point_t             pt;
  } dir_row_t;

  localparam int NUM_PHASES       = 8;
  localparam int ITEMS_PER_PHASE  = 118;
  localparam int HOLD_OFF_CYCLES  = 80;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  sample_t            sample = '0;
  logic               point_valid;
  logic               point_stall = 1'b0;
  point_t             point;

  // shadow calibration
  logic [SAMPLE_BITS-1:0] cal_thr;
  logic [SAMPLE_BITS-1:0] cal_x_lo;
  logic [SAMPLE_BITS-1:0] cal_x_hi;
  logic [SAMPLE_BITS-1:0] cal_y_lo;
  logic [SAMPLE_BITS-1:0] cal_y_hi;
  logic [SIZE_W-1:0]      cal_width;
  logic [SIZE_W-1:0]      cal_height;
  logic [MODE_W-1:0]      cal_mode;

  point_t   expected_points [$];
  dir_row_t dir_rows [$];
  int       errors = 0;
  int       gap_pct = 0;
  int       stall_pct = 0;
  int       hold_off_req = 0;
  bit       burst = 1'b0;
  bit       offering = 1'b0;

  int gap_plan   [NUM_PHASES] = '{0, 30, 10, 60, 20, 80, 5, 40};
  int stall_plan [NUM_PHASES] = '{0, 30, 10, 20, 60, 5, 80, 40};

  touch_point_calibrate uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic int unsigned axis_span(logic [SIZE_W-1:0] size);
    if (size == 0) return 0;
    if (size - 1 > 4095) return 4095;
    return size - 1;
  endfunction

  function automatic logic [COORD_W-1:0] scale_coord(int unsigned raw, int unsigned lo,
                                                     int unsigned hi, int unsigned span,
                                                     bit invert);
    int unsigned r;
    int unsigned v;
    r = raw;
    if (lo == hi) return '0;
    if (lo > hi) begin
      v = span;
    end else begin
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      v = ((r - lo) * span) / (hi - lo);
    end
    if (v > span) v = span;
    if (invert) v = span - v;
    return v[COORD_W-1:0];
  endfunction

  function automatic point_t calib_point(sample_t s);
    point_t                 pt;
    logic [SAMPLE_BITS-1:0] rx;
    logic [SAMPLE_BITS-1:0] ry;
    pt = '0;
    if (s.pressure < cal_thr) return pt;
    rx = s.raw_x;
    ry = s.raw_y;
    if (cal_mode[MODE_SWAP]) begin
      rx = s.raw_y;
      ry = s.raw_x;
    end
    pt.point_x  = scale_coord(rx, cal_x_lo, cal_x_hi, axis_span(cal_width),
                              cal_mode[MODE_INV_X]);
    pt.point_y  = scale_coord(ry, cal_y_lo, cal_y_hi, axis_span(cal_height),
                              cal_mode[MODE_INV_Y]);
    pt.strength = s.pressure;
    pt.touches  = 1'b1;
    pt.pressed  = 1'b1;
    return pt;
  endfunction

  function automatic logic [PDATA_W-1:0] reg_value(reg_idx_t idx);
    logic [PDATA_W-1:0] v;
    v = '0;
    case (idx)
      REG_THRESHOLD: v[SAMPLE_BITS-1:0] = cal_thr;
      REG_X_MIN:     v[SAMPLE_BITS-1:0] = cal_x_lo;
      REG_X_MAX:     v[SAMPLE_BITS-1:0] = cal_x_hi;
      REG_Y_MIN:     v[SAMPLE_BITS-1:0] = cal_y_lo;
      REG_Y_MAX:     v[SAMPLE_BITS-1:0] = cal_y_hi;
      REG_WIDTH:     v[SIZE_W-1:0]      = cal_width;
      REG_HEIGHT:    v[SIZE_W-1:0]      = cal_height;
      REG_MODE:      v[MODE_W-1:0]      = cal_mode;
      default:       v = '0;
    endcase
    return v;
  endfunction

  // ---------------- directed table rows ----------------

  function automatic sample_t mk_sample(int unsigned p, int unsigned x, int unsigned y);
    sample_t s;
    s.pressure = p[SAMPLE_BITS-1:0];
    s.raw_x    = x[SAMPLE_BITS-1:0];
    s.raw_y    = y[SAMPLE_BITS-1:0];
    return s;
  endfunction

  function automatic dir_row_t row_reg(reg_idx_t idx, int unsigned v);
    dir_row_t r;
    r = '0;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.value = v;
    return r;
  endfunction

  function automatic dir_row_t row_pred(int unsigned p, int unsigned x, int unsigned y);
    dir_row_t r;
    r = '0;
    r.kind = ROW_PREDICT;
    r.smp  = mk_sample(p, x, y);
    return r;
  endfunction

  function automatic dir_row_t row_exp(int unsigned p, int unsigned x, int unsigned y,
                                       int unsigned px, int unsigned py, int unsigned st,
                                       bit hit);
    dir_row_t r;
    r = '0;
    r.kind        = ROW_KNOWN;
    r.smp         = mk_sample(p, x, y);
    r.pt.point_x  = px[COORD_W-1:0];
    r.pt.point_y  = py[COORD_W-1:0];
    r.pt.strength = st[SAMPLE_BITS-1:0];
    r.pt.touches  = hit;
    r.pt.pressed  = hit;
    return r;
  endfunction

  // ---------------- random picks ----------------

  function automatic int unsigned near(int unsigned v);
    int d;
    d = int'($urandom_range(0, 4)) - 2 + int'(v);
    if (d < 0) d = 0;
    if (d > 4095) d = 4095;
    return d;
  endfunction

  function automatic int unsigned random_raw();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 4095 : 0;
      1:       return near(cal_x_lo);
      2:       return near(cal_x_hi);
      3:       return near(cal_y_lo);
      4:       return near(cal_y_hi);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic sample_t random_sample();
    int unsigned p;
    case ($urandom_range(0, 9))
      0, 1:    p = near(cal_thr);
      2:       p = $urandom_range(0, 1) ? 4095 : 0;
      default: p = $urandom_range(0, 4095);
    endcase
    return mk_sample(p, random_raw(), random_raw());
  endfunction

  function automatic logic [PDATA_W-1:0] with_noise(int unsigned v, int w);
    logic [PDATA_W-1:0] junk;
    junk = $urandom();
    if ($urandom_range(0, 1)) return v | (junk << w);
    return v;
  endfunction

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return 1;
      2:       return 4096;
      3:       return 8191;
      4:       return $urandom_range(4097, 8191);
      5:       return 2;
      default: return $urandom_range(2, 1024);
    endcase
  endfunction

  function automatic int pick_gap();
    if (burst || $urandom_range(0, 99) >= gap_pct) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // ---------------- bus tasks ----------------

  task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_THRESHOLD: cal_thr    = data[SAMPLE_BITS-1:0];
      REG_X_MIN:     cal_x_lo   = data[SAMPLE_BITS-1:0];
      REG_X_MAX:     cal_x_hi   = data[SAMPLE_BITS-1:0];
      REG_Y_MIN:     cal_y_lo   = data[SAMPLE_BITS-1:0];
      REG_Y_MAX:     cal_y_hi   = data[SAMPLE_BITS-1:0];
      REG_WIDTH:     cal_width  = data[SIZE_W-1:0];
      REG_HEIGHT:    cal_height = data[SIZE_W-1:0];
      REG_MODE:      cal_mode   = data[MODE_W-1:0];
      default:       ;
    endcase
  endtask

  task automatic apb_readback(reg_idx_t idx);
    logic [PDATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== reg_value(idx)) begin
      $error("prdata[%s]: expected %0d, got %0d", idx.name(), reg_value(idx), got);
      errors++;
    end
  endtask

  task automatic readback_all();
    for (int r = 0; r < REG_COUNT; r++) apb_readback(reg_idx_t'(r));
  endtask

  task automatic write_window(reg_idx_t lo_reg, reg_idx_t hi_reg);
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(0, 9))
      0: begin
        lo = $urandom_range(0, 4095);
        hi = lo;
      end
      1: begin
        lo = $urandom_range(1, 4095);
        hi = $urandom_range(0, lo - 1);
      end
      2: begin
        lo = 0;
        hi = 4095;
      end
      default: begin
        lo = $urandom_range(0, 3500);
        hi = $urandom_range(lo + 1, 4095);
      end
    endcase
    apb_write(lo_reg, with_noise(lo, SAMPLE_BITS));
    apb_write(hi_reg, with_noise(hi, SAMPLE_BITS));
  endtask

  task automatic load_random_calib();
    int unsigned thr;
    case ($urandom_range(0, 9))
      0, 1:    thr = 0;
      2:       thr = 4095;
      3:       thr = $urandom_range(0, 4095);
      default: thr = $urandom_range(0, 1500);
    endcase
    apb_write(REG_THRESHOLD, with_noise(thr, SAMPLE_BITS));
    write_window(REG_X_MIN, REG_X_MAX);
    write_window(REG_Y_MIN, REG_Y_MAX);
    apb_write(REG_WIDTH, with_noise(pick_size(), SIZE_W));
    apb_write(REG_HEIGHT, with_noise(pick_size(), SIZE_W));
    apb_write(REG_MODE, with_noise($urandom_range(0, 7), MODE_W));
    readback_all();
  endtask

  // ---------------- stream tasks ----------------

  task automatic send_sample(sample_t s, point_t exp_pt);
    int gap;
    sample_valid <= 1'b1;
    sample       <= s;
    offering = 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    expected_points.push_back(exp_pt);
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_points();
    if (offering) begin
      sample_valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  // ---------------- output side ----------------

  initial begin : point_sink
    int     stall_left;
    point_t exp_pt;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && point_valid === 1'b1 && !point_stall) begin
        if (expected_points.size() == 0) begin
          $error("point beat with nothing expected");
          errors++;
        end else begin
          exp_pt = expected_points.pop_front();
          if (point.point_x !== exp_pt.point_x) begin
            $error("point_x: expected %0d, got %0d", exp_pt.point_x, point.point_x);
            errors++;
          end
          if (point.point_y !== exp_pt.point_y) begin
            $error("point_y: expected %0d, got %0d", exp_pt.point_y, point.point_y);
            errors++;
          end
          if (point.strength !== exp_pt.strength) begin
            $error("strength: expected %0d, got %0d", exp_pt.strength, point.strength);
            errors++;
          end
          if (point.touches !== exp_pt.touches) begin
            $error("touches: expected %0d, got %0d", exp_pt.touches, point.touches);
            errors++;
          end
          if (point.pressed !== exp_pt.pressed) begin
            $error("pressed: expected %0d, got %0d", exp_pt.pressed, point.pressed);
            errors++;
          end
        end
      end
      if (hold_off_req > 0) begin
        stall_left = hold_off_req;
        hold_off_req = 0;
      end
      if (stall_left > 0) begin
        point_stall <= 1'b1;
        stall_left--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        point_stall <= 1'b1;
        stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40)
                                                  : $urandom_range(0, 2);
      end else begin
        point_stall <= 1'b0;
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin : stimulus
    dir_row_t row;
    sample_t  s;

    dir_rows = '{
      row_exp(0, 0, 0, 0, 0, 0, 1),
      row_exp(4095, 4095, 4095, 319, 239, 4095, 1),
      row_pred(1, 2048, 1000),
      row_pred(2222, 1, 4094),
      row_reg(REG_THRESHOLD, 2048),
      row_exp(2047, 4095, 4095, 0, 0, 0, 0),
      row_exp(2048, 0, 4095, 0, 239, 2048, 1),
      row_reg(REG_MODE, 1),
      row_exp(4095, 4095, 0, 0, 239, 4095, 1),
      row_reg(REG_MODE, 2),
      row_exp(3000, 0, 0, 319, 0, 3000, 1),
      row_reg(REG_MODE, 4),
      row_exp(3000, 0, 0, 0, 239, 3000, 1),
      row_reg(REG_MODE, 7),
      row_exp(4095, 4095, 0, 319, 0, 4095, 1),
      row_pred(2500, 1234, 3210),
      row_reg(REG_MODE, 2),
      row_reg(REG_X_MIN, 1000),
      row_reg(REG_X_MAX, 1000),
      row_exp(4095, 1000, 0, 0, 0, 4095, 1),        // empty window, inverted
      row_reg(REG_X_MIN, 3000),
      row_exp(4095, 2000, 4095, 0, 239, 4095, 1),   // reversed window, inverted
      row_reg(REG_MODE, 0),
      row_exp(4095, 2000, 4095, 319, 239, 4095, 1),
      row_reg(REG_X_MIN, 1000),
      row_reg(REG_X_MAX, 3000),
      row_exp(3000, 500, 0, 0, 0, 3000, 1),
      row_exp(3000, 3500, 0, 319, 0, 3000, 1),
      row_pred(3000, 2000, 2000),
      row_reg(REG_WIDTH, 0),
      row_exp(3000, 3500, 0, 0, 0, 3000, 1),
      row_reg(REG_WIDTH, 8191),
      row_reg(REG_HEIGHT, 4096),
      row_exp(3000, 3500, 4095, 4095, 4095, 3000, 1),
      row_reg(REG_HEIGHT, 1),
      row_exp(3000, 3500, 4095, 4095, 0, 3000, 1),
      row_reg(REG_THRESHOLD, 4095),
      row_exp(4094, 3500, 4095, 0, 0, 0, 0),
      row_exp(4095, 2000, 2000, 2047, 0, 4095, 1)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    cal_thr    = '0;
    cal_x_lo   = '0;
    cal_x_hi   = SAMPLE_BITS'(4095);
    cal_y_lo   = '0;
    cal_y_hi   = SAMPLE_BITS'(4095);
    cal_width  = SIZE_W'(320);
    cal_height = SIZE_W'(240);
    cal_mode   = '0;
    readback_all();

    gap_pct   = 20;
    stall_pct = 20;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_CFG: begin
          drain_points();
          apb_write(row.idx, row.value);
        end
        ROW_PREDICT: send_sample(row.smp, calib_point(row.smp));
        ROW_KNOWN:   send_sample(row.smp, row.pt);
        default:     ;
      endcase
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_points();
      load_random_calib();
      gap_pct   = gap_plan[phase];
      stall_pct = stall_plan[phase];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long output hold-off with the input kept busy: fills the pipe
        if (phase == 2 && i == 20) begin
          hold_off_req = HOLD_OFF_CYCLES;
          burst = 1'b1;
        end
        if (phase == 2 && i == 60) burst = 1'b0;
        if (phase == 5 && i == 50) drain_points();
        s = random_sample();
        send_sample(s, calib_point(s));
      end
    end

    drain_points();
    repeat (3 * PIPE_DEPTH) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* touch_point_calibrate.f */
+incdir+hw/rtl
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_regs.sv
hw/rtl/tpc_front.sv
hw/rtl/tpc_div_stage.sv
hw/rtl/tpc_back.sv
hw/rtl/touch_point_calibrate.sv
sim/tb_touch_point_calibrate.sv
